FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the lexer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// prop must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

FILE: rtl/core/clx_pkg.sv
// Types, constants and character helpers for the C subset lexer.
// No dependencies; imported by every lexer module.
package clx_pkg;

  localparam int MAX_WORD_CHARS = 8;
  localparam int WORD_BITS      = 8 * MAX_WORD_CHARS;
  localparam int QUEUE_DEPTH    = 4;
  localparam int PTR_W          = $clog2(QUEUE_DEPTH);
  localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUM,
    MODE_SYM
  } scan_mode_e;

  typedef enum logic [4:0] {
    K_CONST, K_IDENT, K_PLUS, K_MINUS, K_STAR, K_LPAREN, K_RPAREN, K_LBRACE,
    K_RBRACE, K_COMMA, K_SEMI, K_NOT, K_LT, K_GT, K_ASSIGN, K_EQ,
    K_NE, K_OR, K_AND, K_GE, K_LE, K_IF, K_INT, K_ELSE,
    K_FOR, K_RETURN, K_DEBUG, K_WHILE, K_EOF, K_ERR_UNSUP, K_ERR_ARRAY, K_ERR_BAD
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e              kind;
    logic [31:0]            value;
    logic                   ovf;
    logic [WORD_BITS-1:0]   chars;
    logic [7:0]             len;
    logic                   last;
  } tok_t;

  // up to two tokens produced by one byte, in order
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       tok0;
    tok_t       tok1;
  } push_t;

  // character codes
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // words packed first character in the low byte
  localparam logic [WORD_BITS-1:0] KW_IF       = 64'h0000_0000_0000_6669;
  localparam logic [WORD_BITS-1:0] KW_INT      = 64'h0000_0000_0074_6E69;
  localparam logic [WORD_BITS-1:0] KW_ELSE     = 64'h0000_0000_6573_6C65;
  localparam logic [WORD_BITS-1:0] KW_FOR      = 64'h0000_0000_0072_6F66;
  localparam logic [WORD_BITS-1:0] KW_RETURN   = 64'h0000_6E72_7574_6572;
  localparam logic [WORD_BITS-1:0] KW_DEBUG    = 64'h0000_0067_7562_6564;
  localparam logic [WORD_BITS-1:0] KW_WHILE    = 64'h0000_0065_6C69_6877;
  localparam logic [WORD_BITS-1:0] KW_SWITCH   = 64'h0000_6863_7469_7773;
  localparam logic [WORD_BITS-1:0] KW_CASE     = 64'h0000_0000_6573_6163;
  localparam logic [WORD_BITS-1:0] KW_BREAK    = 64'h0000_006B_6165_7262;
  localparam logic [WORD_BITS-1:0] KW_CONTINUE = 64'h6575_6E69_746E_6F63;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // symbols that wait one byte for a possible second character
  function automatic logic is_hold(logic [7:0] c);
    return c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT ||
           c == CH_BAR || c == CH_AMP;
  endfunction

  // whole-word keyword match; unsupported words map to the error kind
  function automatic tok_kind_e word_kind(logic [WORD_BITS-1:0] w, logic [7:0] n);
    tok_kind_e k;
    k = K_IDENT;
    if      (n == 8'd2 && w == KW_IF)       k = K_IF;
    else if (n == 8'd3 && w == KW_INT)      k = K_INT;
    else if (n == 8'd4 && w == KW_ELSE)     k = K_ELSE;
    else if (n == 8'd3 && w == KW_FOR)      k = K_FOR;
    else if (n == 8'd6 && w == KW_RETURN)   k = K_RETURN;
    else if (n == 8'd5 && w == KW_DEBUG)    k = K_DEBUG;
    else if (n == 8'd5 && w == KW_WHILE)    k = K_WHILE;
    else if (n == 8'd6 && w == KW_SWITCH)   k = K_ERR_UNSUP;
    else if (n == 8'd4 && w == KW_CASE)     k = K_ERR_UNSUP;
    else if (n == 8'd5 && w == KW_BREAK)    k = K_ERR_UNSUP;
    else if (n == 8'd8 && w == KW_CONTINUE) k = K_ERR_UNSUP;
    return k;
  endfunction

  // K_CONST means no two-character operator
  function automatic tok_kind_e pair_kind(logic [7:0] p, logic [7:0] c);
    tok_kind_e k;
    k = K_CONST;
    if      (p == CH_EQ   && c == CH_EQ)  k = K_EQ;
    else if (p == CH_BANG && c == CH_EQ)  k = K_NE;
    else if (p == CH_BAR  && c == CH_BAR) k = K_OR;
    else if (p == CH_AMP  && c == CH_AMP) k = K_AND;
    else if (p == CH_GT   && c == CH_EQ)  k = K_GE;
    else if (p == CH_LT   && c == CH_EQ)  k = K_LE;
    return k;
  endfunction

  // a held symbol that was not doubled; lone bar or ampersand is bad
  function automatic tok_kind_e single_kind(logic [7:0] p);
    tok_kind_e k;
    case (p)
      CH_EQ:   k = K_ASSIGN;
      CH_BANG: k = K_NOT;
      CH_LT:   k = K_LT;
      CH_GT:   k = K_GT;
      default: k = K_ERR_BAD;
    endcase
    return k;
  endfunction

  // token for a byte that stands alone
  function automatic tok_kind_e start_kind(logic [7:0] c);
    tok_kind_e k;
    case (c)
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_STAR;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_COMMA:  k = K_COMMA;
      CH_SEMI:   k = K_SEMI;
      CH_LBRACK: k = K_ERR_ARRAY;
      CH_RBRACK: k = K_ERR_ARRAY;
      default:   k = K_ERR_BAD;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/core/clx_if.sv
// Valid/ready channel interfaces of the lexer: source bytes in, tokens out.
// No dependencies.
interface clx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface clx_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [31:0] number_value;
  logic        number_overflow;
  logic [63:0] word_chars;
  logic [7:0]  word_length;
  logic        last;

  modport source (output valid, output kind, output number_value, output number_overflow,
                  output word_chars, output word_length, output last, input ready);
  modport sink   (input valid, input kind, input number_value, input number_overflow,
                  input word_chars, input word_length, input last, output ready);
endinterface

FILE: rtl/core/c_subset_lexer.sv
// Top level of the C subset lexer: front end, token queue, output stage.
// Depends on clx_pkg, clx_if, clx_front, clx_fifo and clx_out.
//
//  channel   dir  transaction                 payload
//  lex_in    in   one source byte or EOT      ch[7:0], end_of_text
//  tok_out   out  one token                   kind, number_value, number_overflow,
//                                             word_chars, word_length, last
//
// Cycles: one byte per cycle while lex_in.ready is high; a byte produces zero,
// one or two tokens. The front end writes tokens into a four-entry queue; the
// output stage drains one token per cycle while tok_out.ready is high.
// lex_in.ready drops while the queue has fewer than two free entries.
// With an empty queue, the first token of a byte is written into the queue when
// the byte is accepted, then registered in the output stage; a second token follows.
// Reset: rst_ni asynchronous, active low; clears scan state, queue and output valid.
module c_subset_lexer import clx_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  clx_in_if.sink     lex_in,
  clx_out_if.source  tok_out
);

  push_t push;
  tok_t  head;
  logic  avail, space2, pop, take;

  // front end only takes a byte when its worst-case two tokens fit
  assign lex_in.ready = space2;
  assign take         = lex_in.valid && space2;

  clx_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .ch_i   (lex_in.ch),
    .eot_i  (lex_in.end_of_text),
    .push_o (push)
  );

  clx_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (head),
    .avail_o  (avail),
    .space2_o (space2)
  );

  clx_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .avail_i (avail),
    .pop_o   (pop),
    .tok_out (tok_out)
  );

endmodule

FILE: rtl/core/clx_front.sv
// Lexer front end: scan state machine, one byte per transaction, up to two tokens out.
// Depends on clx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clx_front import clx_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] ch_i,
  input  logic       eot_i,
  output push_t      push_o
);

  localparam int PW = VALUE_BITS + 4;

  scan_mode_e             mode_q, mode_d;
  logic [WORD_BITS-1:0]   wbuf_q, wbuf_d;
  logic [7:0]             wcnt_q, wcnt_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic                   sat_q, sat_d;
  logic [7:0]             pend_q, pend_d;
  logic                   err_q, err_d;

  logic      c_let, c_dig, c_spc, c_hold;
  tok_kind_e pk;
  logic      pair_hit, ext_word, ext_num;
  logic [PW-1:0] acc_w, prod;
  logic      num_ovf;
  logic [63:0] acc_ext;

  tok_t      ftok, stok, ptok, etok, tok_a, tok_b;
  logic      f_vld, f_err, s_vld, s_err;
  logic      a_vld, b_vld;
  tok_kind_e wk, sk;

  // byte classes and operator merge
  assign c_let    = is_letter(ch_i);
  assign c_dig    = is_digit(ch_i);
  assign c_spc    = is_space(ch_i);
  assign c_hold   = is_hold(ch_i);
  assign pk       = pair_kind(pend_q, ch_i);
  assign pair_hit = (mode_q == MODE_SYM) && (pk != K_CONST);
  assign ext_word = (mode_q == MODE_WORD) && c_let;
  assign ext_num  = (mode_q == MODE_NUM) && c_dig;

  // acc*10 + digit, saturating
  assign acc_w   = PW'(acc_q);
  assign prod    = (acc_w << 3) + (acc_w << 1) + PW'(ch_i[3:0]);
  assign num_ovf = sat_q || (prod[PW-1:VALUE_BITS] != '0);
  assign acc_ext = 64'(acc_q);

  // candidate tokens
  always_comb begin
    ftok  = '0;
    f_vld = 1'b0;
    f_err = 1'b0;
    wk    = word_kind(wbuf_q, wcnt_q);
    sk    = single_kind(pend_q);
    case (mode_q)
      MODE_WORD: begin
        f_vld     = 1'b1;
        ftok.kind = wk;
        if (wk == K_IDENT) begin
          ftok.chars = wbuf_q;
          ftok.len   = wcnt_q;
        end
        f_err = (wk == K_ERR_UNSUP);
      end
      MODE_NUM: begin
        f_vld      = 1'b1;
        ftok.kind  = K_CONST;
        ftok.value = acc_ext[31:0];
        ftok.ovf   = sat_q;
      end
      MODE_SYM: begin
        f_vld     = 1'b1;
        ftok.kind = sk;
        f_err     = (sk == K_ERR_BAD);
      end
      default: ;
    endcase

    stok      = '0;
    stok.kind = start_kind(ch_i);
    s_vld     = !c_spc && !c_let && !c_dig && !c_hold;
    s_err     = (stok.kind == K_ERR_ARRAY) || (stok.kind == K_ERR_BAD);

    ptok      = '0;
    ptok.kind = pk;
    etok      = '0;
    etok.kind = K_EOF;
  end

  // next scan state
  always_comb begin
    mode_d = mode_q;
    wbuf_d = wbuf_q;
    wcnt_d = wcnt_q;
    acc_d  = acc_q;
    sat_d  = sat_q;
    pend_d = pend_q;
    err_d  = err_q;
    if (take_i) begin
      if (eot_i) begin
        mode_d = MODE_IDLE;
        err_d  = 1'b0;
      end else if (!err_q) begin
        if (pair_hit) begin
          mode_d = MODE_IDLE;
        end else if (ext_word) begin
          if (wcnt_q < 8'(MAX_WORD_CHARS)) begin
            wbuf_d[{wcnt_q[2:0], 3'b000} +: 8] = ch_i;
          end
          if (wcnt_q != 8'hFF) begin
            wcnt_d = wcnt_q + 8'd1;
          end
        end else if (ext_num) begin
          if (num_ovf) begin
            acc_d = '1;
            sat_d = 1'b1;
          end else begin
            acc_d = prod[VALUE_BITS-1:0];
          end
        end else begin
          mode_d = MODE_IDLE;
          if (f_err) begin
            err_d = 1'b1;
          end else if (c_let) begin
            mode_d = MODE_WORD;
            wbuf_d = WORD_BITS'(ch_i);
            wcnt_d = 8'd1;
          end else if (c_dig) begin
            mode_d = MODE_NUM;
            acc_d  = VALUE_BITS'(ch_i[3:0]);
            sat_d  = 1'b0;
          end else if (c_hold) begin
            mode_d = MODE_SYM;
            pend_d = ch_i;
          end else if (s_vld && s_err) begin
            err_d = 1'b1;
          end
        end
      end
    end
  end

  // tokens of this byte, packed to the front, last flag on the final one
  always_comb begin
    tok_a = ftok;
    tok_b = stok;
    a_vld = 1'b0;
    b_vld = 1'b0;
    if (eot_i) begin
      a_vld = !err_q && f_vld;
      tok_b = etok;
      b_vld = 1'b1;
    end else if (!err_q) begin
      if (pair_hit) begin
        tok_a = ptok;
        a_vld = 1'b1;
      end else if (!ext_word && !ext_num) begin
        a_vld = f_vld;
        b_vld = !f_err && s_vld;
      end
    end

    push_o = '0;
    if (a_vld) begin
      push_o.tok0 = tok_a;
      push_o.tok1 = tok_b;
      push_o.cnt  = b_vld ? 2'd2 : 2'd1;
    end else begin
      push_o.tok0 = tok_b;
      push_o.cnt  = b_vld ? 2'd1 : 2'd0;
    end
    push_o.tok0.last = (push_o.cnt == 2'd1);
    push_o.tok1.last = (push_o.cnt == 2'd2);
    if (!take_i) begin
      push_o.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      wbuf_q <= '0;
      wcnt_q <= '0;
      acc_q  <= '0;
      sat_q  <= 1'b0;
      pend_q <= '0;
      err_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      wbuf_q <= wbuf_d;
      wcnt_q <= wcnt_d;
      acc_q  <= acc_d;
      sat_q  <= sat_d;
      pend_q <= pend_d;
      err_q  <= err_d;
    end
  end

  `ASSERT_AT(a_err_idle, clk_i, rst_ni, err_q |-> (mode_q == MODE_IDLE), "error with scan active")
  `ASSERT_AT(a_eot_clear, clk_i, rst_ni, (take_i && eot_i) |=> (!err_q && mode_q == MODE_IDLE), "end of text did not reset scan")
  `ASSERT_NEVER(a_push_cnt, clk_i, rst_ni, push_o.cnt == 2'd3, "more than two tokens per byte")

endmodule

FILE: rtl/core/clx_fifo.sv
// Token queue between front end and output stage: two writes, one read per cycle.
// Depends on clx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clx_fifo import clx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  logic  pop_i,
  output tok_t  head_o,
  output logic  avail_o,
  output logic  space2_o
);

  tok_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PTR_W-1:0] wr_nxt;

  assign wr_nxt   = wr_q + PTR_W'(1);
  assign wr_d     = wr_q + PTR_W'(push_i.cnt);
  assign rd_d     = rd_q + PTR_W'(pop_i);
  assign cnt_d    = cnt_q + CNT_W'(push_i.cnt) - CNT_W'(pop_i);
  assign head_o   = mem_q[rd_q];
  assign avail_o  = (cnt_q != '0);
  assign space2_o = (cnt_q <= CNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.tok0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nxt] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `ASSERT_AT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(QUEUE_DEPTH), "queue count past depth")
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && (cnt_q == '0), "pop from empty queue")
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, CNT_W'(push_i.cnt) > (CNT_W'(QUEUE_DEPTH) - cnt_q), "push into full queue")

endmodule

FILE: rtl/core/clx_out.sv
// Output stage: pops the token queue into a registered valid/ready source.
// Depends on clx_pkg and clx_if.
module clx_out import clx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tok_t        head_i,
  input  logic        avail_i,
  output logic        pop_o,
  clx_out_if.source   tok_out
);

  logic vld_q, vld_d;
  tok_t tok_q;

  assign pop_o = avail_i && (!vld_q || tok_out.ready);

  always_comb begin
    vld_d = vld_q;
    if (pop_o) begin
      vld_d = 1'b1;
    end else if (tok_out.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tok_q <= head_i;
    end
  end

  assign tok_out.valid           = vld_q;
  assign tok_out.kind            = tok_q.kind;
  assign tok_out.number_value    = tok_q.value;
  assign tok_out.number_overflow = tok_q.ovf;
  assign tok_out.word_chars      = tok_q.chars;
  assign tok_out.word_length     = tok_q.len;
  assign tok_out.last            = tok_q.last;

endmodule

FILE: bench/c_subset_lexer_tb.sv
// Self-checking bench for c_subset_lexer: drives source bytes, predicts tokens, compares.
// Depends on clx_pkg and clx_if from the RTL and on c_subset_lexer itself.
module c_subset_lexer_tb;
  import clx_pkg::*;

  // run control
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 24;     // margin after the last predicted token is taken
  localparam int CYCLE_LIMIT  = 60000;  // far above the slowest legal run
  localparam int ITEM_GOAL    = 1350;
  localparam int IDLE_PCT     = 11;
  localparam int CALM_FROM    = 700;    // window with no idling on either side
  localparam int CALM_TO      = 1100;
  localparam int HOLD_AT      = 300;    // receiver holds off here ...
  localparam int HOLD_LEN     = 60;     // ... for this many cycles

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } src_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // local copies of every block input, known from time zero
  logic       in_valid  = 1'b0;
  logic [7:0] in_ch     = 8'h00;
  logic       in_eot    = 1'b0;
  logic       out_ready = 1'b0;

  clx_in_if  lex_in ();
  clx_out_if tok_out ();

  assign lex_in.valid       = in_valid;
  assign lex_in.ch          = in_ch;
  assign lex_in.end_of_text = in_eot;
  assign tok_out.ready      = out_ready;

  c_subset_lexer uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .lex_in  (lex_in),
    .tok_out (tok_out)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  src_item_t src_items[$];       // bytes still to be offered
  tok_t      expected_toks[$];   // predicted tokens, oldest first
  src_item_t driver_item;
  tok_t      want;
  int        total_items   = 0;  // everything queued, ignored bytes included
  int        fed_items     = 0;  // items that count toward the goal
  int        accepted_count = 0;
  int        mismatches    = 0;
  int        cycle         = 0;
  int        hold_left     = 0;
  logic      calm;

  assign calm = (cycle >= CALM_FROM) && (cycle < CALM_TO);

  string keywords [7]    = '{"if", "int", "else", "for", "return", "debug", "while"};
  string unsupported [4] = '{"switch", "case", "break", "continue"};
  string doubles [6]     = '{"==", "!=", "||", "&&", ">=", "<="};
  string singles         = "+-*(){},;!<>=";
  string blanks          = " \t\n\v\f\r";

  // ---------------------------------------------------------------------------
  // Token predictor: tracks the scanner state byte by byte
  // ---------------------------------------------------------------------------
  scan_mode_e  scan;
  logic [63:0] word_buf;    // first eight letters, first in low byte
  logic [7:0]  word_count;  // saturates at 255
  logic [31:0] num_acc;
  logic        num_sat;
  logic [7:0]  held_sym;    // symbol waiting for a possible second char
  logic        in_error;    // set by an error token, cleared by end of text

  function automatic void clear_scan_state();
    scan       = MODE_IDLE;
    word_buf   = '0;
    word_count = '0;
    num_acc    = '0;
    num_sat    = 1'b0;
    held_sym   = '0;
  endfunction

  function automatic void add_tok(tok_kind_e k, logic [31:0] v, logic o,
                                  logic [63:0] w, logic [7:0] n);
    tok_t t;
    t.kind  = k;
    t.value = v;
    t.ovf   = o;
    t.chars = w;
    t.len   = n;
    t.last  = 1'b0;
    expected_toks.push_back(t);
  endfunction

  function automatic bit letter_byte(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit blank_byte(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // whole-word match of the collected letters against one spelling
  function automatic bit is_word(string s);
    logic [63:0] spelled;
    spelled = '0;
    for (int i = 0; i < s.len(); i++) spelled[8*i +: 8] = s[i];
    return word_count == 8'(s.len()) && word_buf == spelled;
  endfunction

  function automatic tok_kind_e spelled_kind();
    tok_kind_e k;
    k = K_IDENT;
    if      (is_word("if"))     k = K_IF;
    else if (is_word("int"))    k = K_INT;
    else if (is_word("else"))   k = K_ELSE;
    else if (is_word("for"))    k = K_FOR;
    else if (is_word("return")) k = K_RETURN;
    else if (is_word("debug"))  k = K_DEBUG;
    else if (is_word("while"))  k = K_WHILE;
    else if (is_word("switch") || is_word("case") || is_word("break") ||
             is_word("continue"))
      k = K_ERR_UNSUP;
    return k;
  endfunction

  // K_CONST stands for "no two-character operator"
  function automatic tok_kind_e merged_op(logic [7:0] p, logic [7:0] c);
    if (p == "=" && c == "=") return K_EQ;
    if (p == "!" && c == "=") return K_NE;
    if (p == "|" && c == "|") return K_OR;
    if (p == "&" && c == "&") return K_AND;
    if (p == ">" && c == "=") return K_GE;
    if (p == "<" && c == "=") return K_LE;
    return K_CONST;
  endfunction

  function automatic tok_kind_e lone_sym_kind(logic [7:0] p);
    case (p)
      "=":     return K_ASSIGN;
      "!":     return K_NOT;
      "<":     return K_LT;
      ">":     return K_GT;
      default: return K_ERR_BAD;   // lone bar or ampersand
    endcase
  endfunction

  // emit whatever is pending; returns 1 when that was an error token
  function automatic bit flush_token();
    tok_kind_e k;
    bit        bad;
    bad = 1'b0;
    case (scan)
      MODE_WORD: begin
        k = spelled_kind();
        if (k == K_IDENT) add_tok(k, '0, 1'b0, word_buf, word_count);
        else add_tok(k, '0, 1'b0, '0, '0);
        bad = (k == K_ERR_UNSUP);
      end
      MODE_NUM: add_tok(K_CONST, num_acc, num_sat, '0, '0);
      MODE_SYM: begin
        k = lone_sym_kind(held_sym);
        add_tok(k, '0, 1'b0, '0, '0);
        bad = (k == K_ERR_BAD);
      end
      default: ;
    endcase
    clear_scan_state();
    if (bad) in_error = 1'b1;
    return bad;
  endfunction

  // a byte seen with nothing pending
  function automatic void open_token(logic [7:0] c);
    tok_kind_e k;
    if (blank_byte(c)) begin
    end else if (letter_byte(c)) begin
      scan       = MODE_WORD;
      word_buf   = 64'(c);
      word_count = 8'd1;
    end else if (digit_byte(c)) begin
      scan    = MODE_NUM;
      num_acc = 32'(c - 8'h30);
      num_sat = 1'b0;
    end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "|" || c == "&") begin
      scan     = MODE_SYM;
      held_sym = c;
    end else begin
      case (c)
        "+":      k = K_PLUS;
        "-":      k = K_MINUS;
        "*":      k = K_STAR;
        "(":      k = K_LPAREN;
        ")":      k = K_RPAREN;
        "{":      k = K_LBRACE;
        "}":      k = K_RBRACE;
        ",":      k = K_COMMA;
        ";":      k = K_SEMI;
        "[", "]": k = K_ERR_ARRAY;
        default:  k = K_ERR_BAD;
      endcase
      if (k == K_ERR_ARRAY || k == K_ERR_BAD) in_error = 1'b1;
      add_tok(k, '0, 1'b0, '0, '0);
    end
  endfunction

  // one accepted transaction on lex_in; appends its tokens to expected_toks
  function automatic void predict_tokens(logic [7:0] c, logic eot);
    int          base;
    bit          go;
    tok_kind_e   k;
    logic [35:0] grown;
    base = expected_toks.size();
    if (eot) begin
      if (!in_error) void'(flush_token());
      add_tok(K_EOF, '0, 1'b0, '0, '0);
      clear_scan_state();
      in_error = 1'b0;
    end else if (!in_error) begin
      go = 1'b1;
      if (scan == MODE_SYM) begin
        k = merged_op(held_sym, c);
        if (k != K_CONST) begin
          add_tok(k, '0, 1'b0, '0, '0);
          clear_scan_state();
          go = 1'b0;
        end
      end else if (scan == MODE_WORD && letter_byte(c)) begin
        // letters past the eighth are counted, not stored
        if (word_count < 8'd8) word_buf[8*word_count +: 8] = c;
        if (word_count != 8'd255) word_count = word_count + 8'd1;
        go = 1'b0;
      end else if (scan == MODE_NUM && digit_byte(c)) begin
        grown = 36'(num_acc) * 36'd10 + 36'(c - 8'h30);
        if (num_sat || grown[35:32] != 4'd0) begin
          num_acc = '1;
          num_sat = 1'b1;
        end else begin
          num_acc = grown[31:0];
        end
        go = 1'b0;
      end
      if (go && !flush_token()) open_token(c);
    end
    if (expected_toks.size() > base) expected_toks[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic void push_item(logic [7:0] c, logic eot, bit counts);
    src_item_t it;
    it.ch  = c;
    it.eot = eot;
    src_items.push_back(it);
    total_items++;
    if (counts) fed_items++;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0, 1'b1);
  endfunction

  function automatic logic [7:0] random_letter();
    return ($urandom_range(1) != 0) ? 8'h61 + 8'($urandom_range(25))
                                    : 8'h41 + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] random_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  // one mostly well-formed token; broke = a sure error follows it
  function automatic void emit_token(output bit broke);
    int pick;
    int len;
    broke = 1'b0;
    pick  = $urandom_range(99);
    if (pick < 20) begin
      // identifier, now and then a keyword with a tail ("integer", "iffy")
      if ($urandom_range(9) == 0) push_text(keywords[$urandom_range(6)]);
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) push_item(random_letter(), 1'b0, 1'b1);
    end else if (pick < 35) begin
      push_text(keywords[$urandom_range(6)]);
    end else if (pick < 37) begin
      push_text(unsupported[$urandom_range(3)]);
      broke = 1'b1;
    end else if (pick < 55) begin
      case ($urandom_range(7))
        0: push_text("4294967295");
        1: push_text("4294967296");
        2: push_text("0");
        3: for (int i = 0; i < 25; i++) push_item(random_digit(), 1'b0, 1'b1);
        default: begin
          len = $urandom_range(1, 9);
          for (int i = 0; i < len; i++) push_item(random_digit(), 1'b0, 1'b1);
        end
      endcase
    end else if (pick < 90) begin
      if ($urandom_range(2) == 0) push_text(doubles[$urandom_range(5)]);
      else push_item(singles[$urandom_range(singles.len() - 1)], 1'b0, 1'b1);
    end else if (pick < 94) begin
      push_item(($urandom_range(1) != 0) ? "|" : "&", 1'b0, 1'b1);
      broke = 1'b1;
    end else if (pick < 96) begin
      push_item(($urandom_range(1) != 0) ? "[" : "]", 1'b0, 1'b1);
      broke = 1'b1;
    end else begin
      // any byte at all: NUL, slash, high half, ...
      push_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int ntok;
    bit broke;
    clear_scan_state();
    in_error = 1'b0;

    // directed: keyword, ge, overflow by one, bracket error with an ignored
    // byte after it, NUL as a bad character, end of text alone
    push_text("if(Ab>=4294967296)");
    push_item(8'hFF, 1'b1, 1'b1);
    push_item("[", 1'b0, 1'b1);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hFF, 1'b1, 1'b1);

    // one word long enough to saturate the length counter
    for (int i = 0; i < 257; i++) push_item(random_letter(), 1'b0, 1'b1);
    push_item(";", 1'b0, 1'b1);
    push_item(8'($urandom_range(255)), 1'b1, 1'b1);

    // random programs: token runs, end of text after each
    while (fed_items < ITEM_GOAL) begin
      ntok = $urandom_range(0, 30);
      for (int t = 0; t < ntok; t++) begin
        emit_token(broke);
        if (broke) begin
          // a blank makes the error certain; what follows is ignored
          push_item(" ", 1'b0, 1'b1);
          repeat ($urandom_range(3)) push_item(8'($urandom_range(255)), 1'b0, 1'b0);
          break;
        end
        if ($urandom_range(1) != 0)
          push_item(blanks[$urandom_range(blanks.len() - 1)], 1'b0, 1'b1);
      end
      push_item(8'($urandom_range(255)), 1'b1, 1'b1);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // accepted_count is updated at the edge, so this wait is conservative
    while (accepted_count != total_items) @(posedge clk);
    while (expected_toks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued bytes, predicts on every accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_ch    <= 8'h00;
      in_eot   <= 1'b0;
    end else begin
      if (in_valid && lex_in.ready) begin
        predict_tokens(in_ch, in_eot);
        accepted_count <= accepted_count + 1;
      end
      // payload may change only when nothing is on offer or it was just taken
      if (!in_valid || lex_in.ready) begin
        if (src_items.size() != 0 &&
            (calm || hold_left != 0 || $urandom_range(99) >= IDLE_PCT)) begin
          driver_item = src_items.pop_front();
          in_valid <= 1'b1;
          in_ch    <= driver_item.ch;
          in_eot   <= driver_item.eot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each token transaction with the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(string what, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (tok_out.valid && out_ready) begin
        if (expected_toks.size() == 0) begin
          $display("%0t: unexpected token, expected none, actual kind %0d",
                   $time, tok_out.kind);
          mismatches++;
        end else begin
          want = expected_toks.pop_front();
          check_field("kind", 64'(want.kind), 64'(tok_out.kind));
          check_field("number_value", 64'(want.value), 64'(tok_out.number_value));
          check_field("number_overflow", 64'(want.ovf), 64'(tok_out.number_overflow));
          check_field("word_chars", want.chars, tok_out.word_chars);
          check_field("word_length", 64'(want.len), 64'(tok_out.word_length));
          check_field("last", 64'(want.last), 64'(tok_out.last));
        end
      end
      // long hold-off fills the token queue and backs up lex_in
      out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // receiver hold-off window, counted on its own
  always @(posedge clk) begin
    if (cycle == HOLD_AT) hold_left <= HOLD_LEN;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // cycle count and timeout
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
